// File: hdl/window_coefficient_generator_unit_assert.svh
// assertion macros for the window coefficient generator
// no dependencies; included by the top level only
`ifndef WINDOW_COEFFICIENT_GENERATOR_UNIT_ASSERT_SVH
`define WINDOW_COEFFICIENT_GENERATOR_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define WCG_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define WCG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WCG_ASSERT(lbl, clk, rst_n, prop, msg)
`define WCG_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: hdl/wcg_pkg.sv
// shared types, constants and the arctangent table of the window generator
// no dependencies
`default_nettype none
package wcg_pkg;
    localparam int HALF_W = 12;
    localparam int IDX_W = 12;
    localparam int KIND_W = 3;
    localparam int COEF_W = 16;
    localparam int CFG_W = 12;
    localparam int MAX_HALF_LENGTH = 2048;
    localparam int FRAC_BITS_DEF = 15;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int NUM_W = 44;
    localparam int QUO_W = 32;
    localparam int REM_W = 12;
    localparam int ANG_W = 34;
    localparam int DIV_STEPS = QUO_W;

    localparam logic [KIND_W-1:0] KIND_RECT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_BART = 3'd1;
    localparam logic [KIND_W-1:0] KIND_HANN = 3'd2;
    localparam logic [KIND_W-1:0] KIND_HAMM = 3'd3;
    localparam logic [KIND_W-1:0] KIND_BLACK = 3'd4;

    localparam logic REG_KIND = 1'b0;
    localparam logic REG_HALF = 1'b1;

    localparam logic [31:0] Q30_PI = 32'd3373259426;
    localparam logic [31:0] Q30_HALF_PI = 32'd1686629713;
    localparam logic [31:0] CORDIC_GAIN = 32'd652032874;
    localparam logic signed [63:0] Q30_ONE = 64'sd1073741824;
    localparam logic signed [31:0] W_HALF = 32'sd536870912;
    localparam logic signed [31:0] W_054 = 32'sd579820585;
    localparam logic signed [31:0] W_046 = 32'sd493921239;
    localparam logic signed [31:0] W_042 = 32'sd450971566;
    localparam logic signed [31:0] W_008 = 32'sd85899346;

    typedef struct packed {
        logic                 v;
        logic                 err;
        logic                 neg;
        logic [KIND_W-1:0]    kind;
        logic [COEF_W-1:0]    bart;
    } t_side;

    function automatic logic [31:0] atan_q30(input int i);
        logic [31:0] a;
        case (i)
            0: a = 32'h3243F6A8;
            1: a = 32'h1DAC6705;
            2: a = 32'h0FADBAFC;
            3: a = 32'h07F56EA6;
            4: a = 32'h03FEAB76;
            5: a = 32'h01FFD55B;
            6: a = 32'h00FFFAAA;
            7: a = 32'h007FFF55;
            8: a = 32'h003FFFEA;
            9: a = 32'h001FFFFD;
            10: a = 32'h000FFFFF;
            11: a = 32'h0007FFFF;
            12: a = 32'h0003FFFF;
            13: a = 32'h0001FFFF;
            14: a = 32'h0000FFFF;
            15: a = 32'h00007FFF;
            16: a = 32'h00003FFF;
            17: a = 32'h00001FFF;
            18: a = 32'h00000FFF;
            19: a = 32'h000007FF;
            20: a = 32'h000003FF;
            21: a = 32'h000001FF;
            22: a = 32'h000000FF;
            23: a = 32'h0000007F;
            default: a = 32'h0;
        endcase
        return a;
    endfunction
endpackage
`default_nettype wire

// File: hdl/wcg_div_cell.sv
// one restoring division step: one quotient bit per cell
// depends on wcg_pkg
`default_nettype none
module wcg_div_cell import wcg_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire t_side            i_side,
    input  wire logic [REM_W-1:0] i_rem,
    input  wire logic [QUO_W-1:0] i_low,
    input  wire logic [REM_W-1:0] i_div,
    output t_side                 o_side,
    output logic [REM_W-1:0]      o_rem,
    output logic [QUO_W-1:0]      o_low,
    output logic [REM_W-1:0]      o_div
);
    logic [REM_W:0] t;
    logic [REM_W:0] diff;
    logic           ge;
    logic [REM_W-1:0] n_rem;
    logic [QUO_W-1:0] n_low;
    t_side          r_side;
    logic [REM_W-1:0] r_rem;
    logic [QUO_W-1:0] r_low;
    logic [REM_W-1:0] r_div;

    always_comb begin
        t = {i_rem, i_low[QUO_W-1]};
        diff = t - {1'b0, i_div};
        ge = (t >= {1'b0, i_div});
        n_rem = ge ? diff[REM_W-1:0] : t[REM_W-1:0];
        // quotient bits fill in behind the numerator bits
        n_low = {i_low[QUO_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= '0;
        end else if (i_en) begin
            r_side <= i_side;
        end
        if (i_en) begin
            r_rem <= n_rem;
            r_low <= n_low;
            r_div <= i_div;
        end
    end

    assign o_side = r_side;
    assign o_rem = r_rem;
    assign o_low = r_low;
    assign o_div = r_div;
endmodule
`default_nettype wire

// File: hdl/wcg_cordic_cell.sv
// one rotation-mode cordic micro-rotation
// depends on wcg_pkg
`default_nettype none
module wcg_cordic_cell import wcg_pkg::*; #(
    parameter int SHIFT = 0
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_en,
    input  wire t_side                   i_side,
    input  wire logic signed [ANG_W-1:0] i_x,
    input  wire logic signed [ANG_W-1:0] i_y,
    input  wire logic signed [ANG_W-1:0] i_z,
    output t_side                        o_side,
    output logic signed [ANG_W-1:0]      o_x,
    output logic signed [ANG_W-1:0]      o_y,
    output logic signed [ANG_W-1:0]      o_z
);
    localparam logic signed [ANG_W-1:0] ATAN = ANG_W'(atan_q30(SHIFT));

    logic signed [ANG_W-1:0] n_x;
    logic signed [ANG_W-1:0] n_y;
    logic signed [ANG_W-1:0] n_z;
    t_side                   r_side;
    logic signed [ANG_W-1:0] r_x;
    logic signed [ANG_W-1:0] r_y;
    logic signed [ANG_W-1:0] r_z;

    always_comb begin
        if (!i_z[ANG_W-1]) begin
            n_x = i_x - (i_y >>> SHIFT);
            n_y = i_y + (i_x >>> SHIFT);
            n_z = i_z - ATAN;
        end else begin
            n_x = i_x + (i_y >>> SHIFT);
            n_y = i_y - (i_x >>> SHIFT);
            n_z = i_z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= '0;
        end else if (i_en) begin
            r_side <= i_side;
        end
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_side = r_side;
    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;
endmodule
`default_nettype wire

// File: hdl/window_coefficient_generator_unit.sv
// channel   | dir | signals                           | note
// config    | in  | i_cfg_we i_cfg_index i_cfg_data   | write only, no wait
// index     | in  | i_valid o_ready i_sample_index    | one request per cycle while o_ready is high
// result    | out | o_valid i_ready o_coefficient ... | one result per request
// the pipeline runs through stages 1 and 2, the 32-cell divider chain, stage 3, the cordic
// cell chain, stages 4 to 7 and the output register; one request per cycle while o_ready is high
// all stages advance together; a skid register behind the output register
// takes one result while the output stalls, then o_ready drops
// synchronous active-low reset clears valid bits and config to their defaults
// depends on wcg_pkg, wcg_div_cell, wcg_cordic_cell and the assertion header
`default_nettype none
`include "window_coefficient_generator_unit_assert.svh"
module window_coefficient_generator_unit import wcg_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_index,
    input  wire logic [CFG_W-1:0]  i_cfg_data,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [IDX_W-1:0]  i_sample_index,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [COEF_W-1:0]      o_coefficient,
    output logic                   o_index_error
);
    localparam int SH = 60 - FRAC_BITS;

    logic [KIND_W-1:0] r_kind;
    logic [HALF_W-1:0] r_half;
    logic              en;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= KIND_RECT;
            r_half <= HALF_W'(256);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_KIND: r_kind <= i_cfg_data[KIND_W-1:0];
                REG_HALF: r_half <= i_cfg_data[HALF_W-1:0];
                default: ;
            endcase
        end
    end

    // stage 1: range check, offset and divisor
    logic [HALF_W-1:0] m_c;
    logic [HALF_W:0]   two_m;
    logic [HALF_W-1:0] n_ak;
    logic [HALF_W-1:0] n_d;
    t_side             n1_side;
    t_side             r1_side;
    logic [HALF_W-1:0] r1_ak;
    logic [HALF_W-1:0] r1_d;

    always_comb begin
        m_c = (r_half > HALF_W'(MAX_HALF_LENGTH)) ? HALF_W'(MAX_HALF_LENGTH) : r_half;
        two_m = {m_c, 1'b0};
        n_ak = (i_sample_index >= m_c) ? i_sample_index - m_c : m_c - i_sample_index;
        n_d = (r_kind == KIND_HANN) ? m_c + HALF_W'(1) : m_c;
        n1_side = '0;
        n1_side.v = i_valid;
        n1_side.err = ({1'b0, i_sample_index} >= two_m);
        n1_side.kind = r_kind;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_side <= '0;
        end else if (en) begin
            r1_side <= n1_side;
        end
        if (en) begin
            r1_ak <= n_ak;
            r1_d <= n_d;
        end
    end

    // stage 2: dividend
    logic [NUM_W-1:0] n_num;
    t_side            r2_side;
    logic [NUM_W-1:0] r2_num;
    logic [HALF_W-1:0] r2_d;

    always_comb begin
        if (r1_side.kind == KIND_BART) begin
            n_num = (NUM_W'(r1_d - r1_ak) << FRAC_BITS) + NUM_W'(r1_d >> 1);
        end else begin
            n_num = NUM_W'(r1_ak) * NUM_W'(Q30_PI) + NUM_W'(r1_d >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_side <= '0;
        end else if (en) begin
            r2_side <= r1_side;
        end
        if (en) begin
            r2_num <= n_num;
            r2_d <= r1_d;
        end
    end

    // divider chain
    t_side             dv_side [0:DIV_STEPS];
    logic [REM_W-1:0]  dv_rem [0:DIV_STEPS];
    logic [QUO_W-1:0]  dv_low [0:DIV_STEPS];
    logic [REM_W-1:0]  dv_div [0:DIV_STEPS];

    assign dv_side[0] = r2_side;
    assign dv_rem[0] = r2_num[NUM_W-1:QUO_W];
    assign dv_low[0] = r2_num[QUO_W-1:0];
    assign dv_div[0] = r2_d;

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        wcg_div_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_side (dv_side[g]),
            .i_rem  (dv_rem[g]),
            .i_low  (dv_low[g]),
            .i_div  (dv_div[g]),
            .o_side (dv_side[g+1]),
            .o_rem  (dv_rem[g+1]),
            .o_low  (dv_low[g+1]),
            .o_div  (dv_div[g+1])
        );
    end

    // stage 3: fold the angle into the first quadrant
    logic [QUO_W-1:0] quo;
    logic [QUO_W-1:0] theta;
    logic [QUO_W-1:0] n_z;
    t_side            n3_side;
    t_side            r3_side;
    logic signed [ANG_W-1:0] r3_z;

    always_comb begin
        quo = dv_low[DIV_STEPS];
        theta = (quo > Q30_PI) ? Q30_PI : quo;
        n3_side = dv_side[DIV_STEPS];
        n3_side.bart = quo[COEF_W-1:0];
        if (theta > Q30_HALF_PI) begin
            n_z = Q30_PI - theta;
            n3_side.neg = 1'b1;
        end else begin
            n_z = theta;
            n3_side.neg = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_side <= '0;
        end else if (en) begin
            r3_side <= n3_side;
        end
        if (en) begin
            r3_z <= signed'(ANG_W'(n_z));
        end
    end

    // cordic chain
    t_side                   cd_side [0:CORDIC_STAGES];
    logic signed [ANG_W-1:0] cd_x [0:CORDIC_STAGES];
    logic signed [ANG_W-1:0] cd_y [0:CORDIC_STAGES];
    logic signed [ANG_W-1:0] cd_z [0:CORDIC_STAGES];

    assign cd_side[0] = r3_side;
    assign cd_x[0] = signed'(ANG_W'(CORDIC_GAIN));
    assign cd_y[0] = '0;
    assign cd_z[0] = r3_z;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
        wcg_cordic_cell #(.SHIFT(g)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_side (cd_side[g]),
            .i_x    (cd_x[g]),
            .i_y    (cd_y[g]),
            .i_z    (cd_z[g]),
            .o_side (cd_side[g+1]),
            .o_x    (cd_x[g+1]),
            .o_y    (cd_y[g+1]),
            .o_z    (cd_z[g+1])
        );
    end

    // stage 4: clamp and sign of the cosine
    logic signed [ANG_W-1:0] xc;
    logic signed [ANG_W-1:0] cs;
    t_side                   r4_side;
    logic signed [31:0]      r4_c;

    always_comb begin
        xc = cd_x[CORDIC_STAGES];
        if (xc > ANG_W'(Q30_ONE)) begin
            xc = ANG_W'(Q30_ONE);
        end else if (xc < -ANG_W'(Q30_ONE)) begin
            xc = -ANG_W'(Q30_ONE);
        end
        cs = cd_side[CORDIC_STAGES].neg ? -xc : xc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_side <= '0;
        end else if (en) begin
            r4_side <= cd_side[CORDIC_STAGES];
        end
        if (en) begin
            r4_c <= cs[31:0];
        end
    end

    // stage 5: weight times cosine, and cosine squared
    logic signed [31:0] wsel;
    t_side              r5_side;
    logic signed [63:0] r5_pc;
    logic [63:0]        r5_sq;

    assign wsel = (r4_side.kind == KIND_HAMM) ? W_046 : W_HALF;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_side <= '0;
        end else if (en) begin
            r5_side <= r4_side;
        end
        if (en) begin
            r5_pc <= 64'(r4_c) * 64'(wsel);
            r5_sq <= unsigned'(64'(r4_c) * 64'(r4_c));
        end
    end

    // stage 6: double-angle term and constant term
    logic [63:0]        sq_r;
    logic signed [33:0] c2;
    logic signed [63:0] n_p2;
    logic signed [63:0] n_base;
    t_side              r6_side;
    logic signed [63:0] r6_pc;
    logic signed [63:0] r6_p2;
    logic signed [63:0] r6_base;

    always_comb begin
        sq_r = r5_sq + (64'(1) << 28);
        c2 = signed'(34'(sq_r >> 29)) - 34'(Q30_ONE);
        n_p2 = '0;
        case (r5_side.kind)
            KIND_HANN: n_base = 64'(W_HALF) <<< 30;
            KIND_HAMM: n_base = 64'(W_054) <<< 30;
            KIND_BLACK: begin
                n_base = 64'(W_042) <<< 30;
                n_p2 = 64'(c2) * 64'(W_008);
            end
            default: n_base = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_side <= '0;
        end else if (en) begin
            r6_side <= r5_side;
        end
        if (en) begin
            r6_pc <= r5_pc;
            r6_p2 <= n_p2;
            r6_base <= n_base;
        end
    end

    // stage 7: sum, clamp, round and select
    logic signed [63:0] wsum;
    logic [63:0]        wrnd;
    logic [COEF_W-1:0]  n_coef;
    t_side              r7_side;
    logic [COEF_W-1:0]  r7_coef;

    always_comb begin
        wsum = r6_base + r6_pc + r6_p2;
        if (wsum < 0) begin
            wsum = '0;
        end else if (wsum > (64'sd1 <<< 60)) begin
            wsum = 64'sd1 <<< 60;
        end
        wrnd = (unsigned'(wsum) + (64'(1) << (SH - 1))) >> SH;
        case (r6_side.kind)
            KIND_BART: n_coef = r6_side.bart;
            KIND_HANN, KIND_HAMM, KIND_BLACK: n_coef = wrnd[COEF_W-1:0];
            default: n_coef = COEF_W'(64'(1) << FRAC_BITS);
        endcase
        if (r6_side.err) begin
            n_coef = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_side <= '0;
        end else if (en) begin
            r7_side <= r6_side;
        end
        if (en) begin
            r7_coef <= n_coef;
        end
    end

    // output register with skid
    logic              push;
    logic              pop;
    logic              r_out_v;
    logic [COEF_W-1:0] r_out_coef;
    logic              r_out_err;
    logic              r_skid_v;
    logic [COEF_W-1:0] r_skid_coef;
    logic              r_skid_err;

    assign en = !r_skid_v;
    assign push = en && r7_side.v;
    assign pop = r_out_v && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || pop) begin
            if (r_skid_v) begin
                r_out_v <= 1'b1;
                r_skid_v <= 1'b0;
                r_out_coef <= r_skid_coef;
                r_out_err <= r_skid_err;
            end else if (push) begin
                r_out_v <= 1'b1;
                r_out_coef <= r7_coef;
                r_out_err <= r7_side.err;
            end else begin
                r_out_v <= 1'b0;
            end
        end else if (push) begin
            r_skid_v <= 1'b1;
            r_skid_coef <= r7_coef;
            r_skid_err <= r7_side.err;
        end
    end

    assign o_ready = en;
    assign o_valid = r_out_v;
    assign o_coefficient = r_out_coef;
    assign o_index_error = r_out_err;

    `WCG_ASSERT(a_err_zero, i_clk, i_rst_n, o_valid && o_index_error |-> o_coefficient == '0, "error result with non-zero coefficient")
    `WCG_ASSERT(a_skid_behind_out, i_clk, i_rst_n, r_skid_v |-> r_out_v, "skid holds a request while output register empty")
    `WCG_ASSERT(a_skid_fill, i_clk, i_rst_n, $rose(r_skid_v) |-> $past(r_out_v && !i_ready), "skid filled without an output stall")
endmodule
`default_nettype wire
